[rtl/nts_pkg.sv]
// ----------------------------------------------------------------------------
// nts_pkg: shared types and constants of the nearest timestamp search
// Commands, status codes, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

    // default table geometry
    localparam int DEPTH_DEF     = 1024;
    localparam int TIME_BITS_DEF = 48;

    // fixed result field widths
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CMD_W      = 2;
    localparam int RES_BITS   = INDEX_W + STATUS_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ORDER = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLAMP_HI,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_HI_CMP,
        S_NEAR_A,
        S_NEAR_B,
        S_NEAR_D,
        S_NEAR_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   index;
    } res_t;

endpackage

`default_nettype wire

[rtl/nts_ram.sv]
// ----------------------------------------------------------------------------
// nts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/nts_cmp.sv]
// ----------------------------------------------------------------------------
// nts_cmp: shared compare and distance unit
// Order of two stamps and their absolute difference.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_cmp #(
    parameter int W = 48
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              a_lt_b,
    output logic              a_eq_b,
    output logic [W-1:0]      abs_diff
);

    logic [W:0] d_ab;
    logic [W:0] d_ba;

    // both directions side by side, pick the non-negative one
    assign d_ab     = {1'b0, a} - {1'b0, b};
    assign d_ba     = {1'b0, b} - {1'b0, a};
    assign a_lt_b   = d_ab[W];
    assign a_eq_b   = (a == b);
    assign abs_diff = d_ab[W] ? d_ba[W-1:0] : d_ab[W-1:0];

endmodule

`default_nettype wire

[rtl/nts_ctrl.sv]
// ----------------------------------------------------------------------------
// nts_ctrl: command sequencer of the timestamp table
// Append, clear and halving search, one RAM read and one compare per step.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ctrl #(
    parameter int DEPTH     = nts_pkg::DEPTH_DEF,
    parameter int TIME_BITS = nts_pkg::TIME_BITS_DEF,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command word
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [nts_pkg::CMD_W-1:0]   in_cmd,
    input  wire logic [TIME_BITS-1:0]        in_stamp,
    // result word
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output nts_pkg::res_t                    res,
    // stamp RAM
    output logic                             ram_we,
    output logic [IDX_W-1:0]                 ram_waddr,
    output logic [TIME_BITS-1:0]             ram_wdata,
    output logic                             ram_re,
    output logic [IDX_W-1:0]                 ram_raddr,
    input  wire logic [TIME_BITS-1:0]        ram_rdata
);

    nts_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    nts_pkg::cmd_t     cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [TIME_BITS-1:0] first_reg, first_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] da_reg, da_next;
    logic [TIME_BITS-1:0] db_reg, db_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    nts_pkg::status_t     res_status_reg, res_status_next;

    logic [TIME_BITS-1:0] cmp_a, cmp_b, cmp_abs;
    logic                 cmp_lt, cmp_eq;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid_calc;
    logic [CNT_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     lo_idx;
    logic                 full;
    logic [IDX_W+nts_pkg::INDEX_W-1:0] idx_ext;

    nts_cmp #(
        .W (TIME_BITS)
    ) u_cmp (
        .a        (cmp_a),
        .b        (cmp_b),
        .a_lt_b   (cmp_lt),
        .a_eq_b   (cmp_eq),
        .abs_diff (cmp_abs)
    );

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];
    assign cnt_m1   = count_reg - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign lo_idx   = lo_reg[IDX_W-1:0];
    assign full     = (count_reg == CNT_W'(DEPTH));

    // mask the slot number to the result field
    assign idx_ext    = {{nts_pkg::INDEX_W{1'b0}}, res_idx_reg};
    assign res.index  = idx_ext[nts_pkg::INDEX_W-1:0];
    assign res.status = res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nts_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        t_reg          <= t_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        da_reg         <= da_next;
        db_reg         <= db_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nts_pkg::S_DECODE;
                end
            end
            nts_pkg::S_DECODE:
            begin
                state_next = nts_pkg::S_DONE;
                if (cmd_reg == nts_pkg::CMD_QUERY && count_reg != '0 && !cmp_lt)
                begin
                    state_next = nts_pkg::S_CLAMP_HI;
                end
            end
            nts_pkg::S_CLAMP_HI:
            begin
                state_next = cmp_lt ? nts_pkg::S_DONE : nts_pkg::S_PROBE_RD;
            end
            nts_pkg::S_PROBE_RD:
            begin
                state_next = (lo_reg <= hi_reg) ? nts_pkg::S_PROBE_CMP : nts_pkg::S_NEAR_A;
            end
            nts_pkg::S_PROBE_CMP:
            begin
                priority if (cmp_lt)
                begin
                    state_next = nts_pkg::S_PROBE_RD;
                end
                else if (cmp_eq)
                begin
                    state_next = nts_pkg::S_DONE;
                end
                else if (mid_reg == '0)
                begin
                    state_next = nts_pkg::S_NEAR_A;
                end
                else
                begin
                    state_next = nts_pkg::S_HI_CMP;
                end
            end
            nts_pkg::S_HI_CMP:
            begin
                state_next = cmp_lt ? nts_pkg::S_NEAR_A : nts_pkg::S_PROBE_RD;
            end
            nts_pkg::S_NEAR_A:
            begin
                state_next = (lo_reg >= cnt_m1) ? nts_pkg::S_DONE : nts_pkg::S_NEAR_B;
            end
            nts_pkg::S_NEAR_B:
            begin
                state_next = nts_pkg::S_NEAR_D;
            end
            nts_pkg::S_NEAR_D:
            begin
                state_next = nts_pkg::S_NEAR_CMP;
            end
            nts_pkg::S_NEAR_CMP:
            begin
                state_next = nts_pkg::S_DONE;
            end
            nts_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = nts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nts_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        t_next          = t_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        count_next      = count_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        cmp_a           = t_reg;
        cmp_b           = first_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = t_reg;
        ram_re          = 1'b0;
        ram_raddr       = mid_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            nts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = nts_pkg::cmd_t'(in_cmd);
                    t_next   = in_stamp;
                end
            end
            nts_pkg::S_DECODE:
            begin
                cmp_b           = (cmd_reg == nts_pkg::CMD_APPEND) ? last_reg : first_reg;
                res_idx_next    = '0;
                res_status_next = nts_pkg::STAT_OK;
                unique case (cmd_reg)
                    nts_pkg::CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    nts_pkg::CMD_APPEND:
                    begin
                        priority if (full)
                        begin
                            res_status_next = nts_pkg::STAT_FULL;
                        end
                        else if (count_reg != '0 && cmp_lt)
                        begin
                            res_status_next = nts_pkg::STAT_ORDER;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            res_idx_next = count_reg[IDX_W-1:0];
                            count_next   = count_reg + 1'b1;
                            last_next    = t_reg;
                            if (count_reg == '0)
                            begin
                                first_next = t_reg;
                            end
                        end
                    end
                    nts_pkg::CMD_QUERY:
                    begin
                        // below the first entry answers slot zero
                        if (count_reg == '0)
                        begin
                            res_status_next = nts_pkg::STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        res_status_next = nts_pkg::STAT_OK;
                    end
                endcase
            end
            nts_pkg::S_CLAMP_HI:
            begin
                cmp_a        = last_reg;
                cmp_b        = t_reg;
                res_idx_next = last_idx;
                lo_next      = '0;
                hi_next      = count_reg;
            end
            nts_pkg::S_PROBE_RD:
            begin
                ram_re    = (lo_reg <= hi_reg);
                ram_raddr = mid_calc[IDX_W-1:0];
                mid_next  = mid_calc[IDX_W-1:0];
            end
            nts_pkg::S_PROBE_CMP:
            begin
                cmp_a     = ram_rdata;
                cmp_b     = t_reg;
                ram_raddr = mid_reg - 1'b1;
                priority if (cmp_lt)
                begin
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                end
                else if (cmp_eq)
                begin
                    res_idx_next = mid_reg;
                end
                else if (mid_reg != '0)
                begin
                    // probe the entry just below for a bracket
                    hi_next = CNT_W'(mid_reg) - 1'b1;
                    ram_re  = 1'b1;
                end
                else
                begin
                    ram_re = 1'b0;
                end
            end
            nts_pkg::S_HI_CMP:
            begin
                cmp_a = ram_rdata;
                cmp_b = t_reg;
                if (cmp_lt)
                begin
                    lo_next = hi_reg;
                end
            end
            nts_pkg::S_NEAR_A:
            begin
                res_idx_next = last_idx;
                ram_raddr    = lo_idx;
                ram_re       = (lo_reg < cnt_m1);
            end
            nts_pkg::S_NEAR_B:
            begin
                cmp_a     = t_reg;
                cmp_b     = ram_rdata;
                da_next   = cmp_abs;
                ram_raddr = lo_idx + 1'b1;
                ram_re    = 1'b1;
            end
            nts_pkg::S_NEAR_D:
            begin
                cmp_a   = t_reg;
                cmp_b   = ram_rdata;
                db_next = cmp_abs;
            end
            nts_pkg::S_NEAR_CMP:
            begin
                // ties keep the lower slot
                cmp_a        = db_reg;
                cmp_b        = da_reg;
                res_idx_next = cmp_lt ? (lo_idx + 1'b1) : lo_idx;
            end
            nts_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/nearest_timestamp_search.sv]
// ----------------------------------------------------------------------------
// nearest_timestamp_search: sorted timestamp table with nearest-entry query
// Appends stamps in order, clears the table and answers nearest-index queries.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                           tuser
//  -------  ---  ------------------------------  ------------------
//  s_*      in   stamp [TIME_BITS-1:0]           command [1:0]
//  m_*      out  index [9:0], status [11:10]     -
//
//  Clear, append, the unused command and a query that is empty or below the
//  first entry end after the decode state; above the last entry, after the
//  clamp check. A search runs halving steps, each a RAM read and a compare,
//  then the neighbor check, all through the one RAM read port and the one
//  shared compare unit. Reset empties the table.
//  s_tready is high only in idle; a full output register holds the sequencer.
//
`default_nettype none

module nearest_timestamp_search #(
    parameter int DEPTH     = nts_pkg::DEPTH_DEF,
    parameter int TIME_BITS = nts_pkg::TIME_BITS_DEF,
    localparam int S_DATA_W = ((TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [S_DATA_W-1:0]             s_tdata,   // stamp, zero pad
    input  wire logic [nts_pkg::CMD_W-1:0]       s_tuser,   // command
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [nts_pkg::OUT_DATA_W-1:0]       m_tdata    // index, status, zero pad
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [TIME_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [TIME_BITS-1:0]  ram_rdata;

    logic                  res_valid;
    logic                  res_ready;
    nts_pkg::res_t         res;

    logic                  m_valid_reg, m_valid_next;
    nts_pkg::res_t         m_res_reg, m_res_next;

    nts_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // only the low TIME_BITS bits of the stamp are used
    nts_ctrl #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_stamp  (s_tdata[TIME_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready)
        begin
            m_valid_next = res_valid;
            if (res_valid)
            begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(nts_pkg::OUT_DATA_W - nts_pkg::RES_BITS){1'b0}},
                       m_res_reg.status, m_res_reg.index};

endmodule

`default_nettype wire
